### hw/rtl/fir_convolution_stream_top_assert.svh
// assertion macros used by the checker file
`ifndef FIR_CONVOLUTION_STREAM_TOP_ASSERT_SVH
`define FIR_CONVOLUTION_STREAM_TOP_ASSERT_SVH

// property checked only outside reset
`define FCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every edge, reset included
`define FCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/fcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_pkg
// Types and constants shared by the streaming convolution filter.
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int DATA_W   = 16;
  localparam int PROD_W   = 32;
  localparam int SUM_W    = 37;
  localparam int CNT_W    = 6;
  localparam int IDX_W    = 5;
  localparam logic [CNT_W-1:0] TAP_COUNT_RESET = 6'd32;

  // item mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_PUSH = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [IDX_W-1:0]         tap_index;
    logic signed [DATA_W-1:0] coefficient;
    logic signed [DATA_W-1:0] sample;
    logic                     last_sample;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] filtered_out;
    logic                    last_out;
  } out_t;

  // control broadcast along the cell chain
  typedef struct packed {
    logic shift;
    logic clear;
    logic mul;
  } cell_ctrl_t;

endpackage

### hw/rtl/fcs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_cell
// One filter tap: a delay line stage, its coefficient and a product register.
// ----------------------------------------------------------------------------
module fcs_cell
  import fcs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] sample_in,
  output logic signed [DATA_W-1:0] sample_out,
  input  logic                     coef_we,
  input  logic signed [DATA_W-1:0] coef_data,
  input  logic                     active,
  output logic signed [PROD_W-1:0] product
);

  logic signed [DATA_W-1:0] hist;
  logic signed [DATA_W-1:0] coef;

  // delay line stage and coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
      coef <= '0;
    end else begin
      if (ctrl.clear) begin
        hist <= '0;
      end else if (ctrl.shift) begin
        hist <= sample_in;
      end
      if (coef_we) begin
        coef <= coef_data;
      end
    end
  end

  // tap product, zero when the tap is beyond the active count
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      product <= active ? PROD_W'(coef * hist) : '0;
    end
  end

  assign sample_out = hist;

endmodule

### hw/rtl/fcs_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_tree
// Registered binary adder tree over the tap products, one level per cycle.
// ----------------------------------------------------------------------------
module fcs_tree
  import fcs_pkg::*;
#(
  parameter int TAPS = 32
) (
  input  logic                    clk,
  input  logic signed [PROD_W-1:0] products [TAPS],
  output logic signed [SUM_W-1:0]  sum
);

  localparam int LEVELS = $clog2(TAPS);
  localparam int PAD    = 1 << LEVELS;

  logic signed [SUM_W-1:0] leaf  [PAD];
  logic signed [SUM_W-1:0] nodes [1:PAD-1];

  // sign extended leaves, zero padded to a power of two
  for (genvar i = 0; i < PAD; i++) begin : g_leaf
    if (i < TAPS) begin : g_used
      assign leaf[i] = SUM_W'(products[i]);
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // internal nodes in heap order, root at index one
  for (genvar i = 1; i < PAD; i++) begin : g_node
    if (2 * i >= PAD) begin : g_bottom
      always_ff @(posedge clk) begin
        nodes[i] <= leaf[2*i-PAD] + leaf[2*i+1-PAD];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        nodes[i] <= nodes[2*i] + nodes[2*i+1];
      end
    end
  end

  assign sum = nodes[1];

endmodule

### hw/rtl/fir_convolution_stream_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_convolution_stream_top
// Streaming FIR convolution: a chain of tap cells and a registered adder tree.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data): a load transaction (mode 0) writes
//   one coefficient and leaves the block ready for the next transaction. A push transaction (mode 1) shifts a
//   sample into the cell chain and yields one output transaction.
//   A push with last_sample also yields (clamped tap count)-1 tail outputs with
//   zeros shifted in; the final one carries last_out, then the delay line clears.
//   out channel (out_valid/out_ready/out_data) is an output register.
//   cfg_we/cfg_data write tap_count while the block is idle.
// Sequence, with L = clog2(TAPS) adder tree levels: the multiply state
//   registers the tap products, the sum state lets them pass the L tree
//   levels and the output state loads the root once the output register is
//   free; tail outputs repeat these states. in_ready is low until idle.
// Reset: delay line and coefficients clear, tap_count is 32, outputs empty.
// Stall: a finished result waits in the output register; the block accepts
//   the next transaction meanwhile and holds a new result until it drains.
// ----------------------------------------------------------------------------
module fir_convolution_stream_top
  import fcs_pkg::*;
#(
  parameter int TAPS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int LEVELS = $clog2(TAPS);
  localparam int NW     = $clog2(TAPS + 1);
  localparam int CW     = $clog2(LEVELS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_t;

  state_t                  state;
  logic [CW-1:0]           cnt;
  logic [NW-1:0]           n_act;
  logic [NW-1:0]           rem;
  logic                    is_last;
  logic [CNT_W-1:0]        tap_count;
  logic [NW-1:0]           n_sel;
  logic                    push;
  logic                    load;
  logic                    out_free;
  cell_ctrl_t              ctrl;
  logic signed [DATA_W-1:0] shift_data;
  logic signed [DATA_W-1:0] chain [TAPS+1];
  logic signed [PROD_W-1:0] products [TAPS];
  logic signed [SUM_W-1:0]  root;

  // handshake decode
  assign in_ready = (state == ST_IDLE);
  assign push     = in_valid && in_ready && (in_data.mode == MODE_PUSH);
  assign load     = in_valid && in_ready && (in_data.mode == MODE_LOAD);
  assign out_free = !out_valid || out_ready;

  // active tap count, clamped to one and to TAPS
  always_comb begin
    if (tap_count == '0) begin
      n_sel = NW'(1);
    end else if (32'(tap_count) > TAPS) begin
      n_sel = NW'(TAPS);
    end else begin
      n_sel = NW'(tap_count);
    end
  end

  // cell chain control
  always_comb begin
    ctrl.shift = push || (state == ST_OUT && out_free && rem != '0);
    ctrl.clear = (state == ST_OUT) && out_free && (rem == '0) && is_last;
    ctrl.mul   = (state == ST_MUL);
    shift_data = push ? in_data.sample : '0;
  end

  assign chain[0] = shift_data;

  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    fcs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sample_in  (chain[j]),
      .sample_out (chain[j+1]),
      .coef_we    (load && (32'(in_data.tap_index) == j)),
      .coef_data  (in_data.coefficient),
      .active     (NW'(j) < n_act),
      .product    (products[j])
    );
  end

  fcs_tree #(
    .TAPS (TAPS)
  ) u_tree (
    .clk      (clk),
    .products (products),
    .sum      (root)
  );

  // sequencer, config register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      n_act     <= NW'(1);
      rem       <= '0;
      is_last   <= 1'b0;
      tap_count <= TAP_COUNT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tap_count <= cfg_data;
      end
      // drained with no new result to load
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (push) begin
            n_act   <= n_sel;
            is_last <= in_data.last_sample;
            rem     <= in_data.last_sample ? n_sel - NW'(1) : '0;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt   <= CW'(LEVELS);
          state <= ST_SUM;
        end
        ST_SUM: begin
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_data.filtered_out <= root;
            out_data.last_out     <= is_last && (rem == '0);
            if (rem != '0) begin
              rem   <= rem - NW'(1);
              state <= ST_MUL;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/fcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_checker
// Port level checks for the streaming convolution filter.
// ----------------------------------------------------------------------------
`include "fir_convolution_stream_top_assert.svh"

module fcs_checker
  import fcs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input in_t              in_data,
  input logic             out_valid,
  input logic             out_ready,
  input out_t             out_data
);

  // a result waiting for the receiver holds
  `FCS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "out held")

  // reset leaves the block empty and ready
  `FCS_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid && in_ready, "reset state")

  // a push transaction keeps the block busy while its sum forms
  `FCS_ASSERT(a_push_busy, in_valid && in_ready && in_data.mode == MODE_PUSH |=> !in_ready, "push busy")

  // a load transaction never closes the input
  `FCS_ASSERT(a_load_ready, in_valid && in_ready && in_data.mode == MODE_LOAD |=> in_ready, "load ready")

endmodule

bind fir_convolution_stream_top fcs_checker u_fcs_checker (.*);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming convolution filter. A scoreboard class
// keeps its own delay line, coefficient store and tap count, predicts every
// output transaction of each accepted push, and compares results in order.
// Directed corner items come first, then randomized coefficient loads and
// sample streams under several tap counts and idling profiles.
// ----------------------------------------------------------------------------
module tb_top;
  import fcs_pkg::*;

  localparam int TB_TAPS      = 32;
  localparam int RANDOM_ITEMS = 300;
  localparam int SETTLE_CYCLES = 20;

  // predicts filter outputs and holds those not yet seen
  class fir_conv_tracker;
    logic signed [DATA_W-1:0] delay_line [TB_TAPS];
    logic signed [DATA_W-1:0] taps [TB_TAPS];
    logic [CNT_W-1:0]         tap_count;
    out_t                     expected_outputs [$];
    int                       errors;

    function new();
      foreach (delay_line[i]) delay_line[i] = '0;
      foreach (taps[i]) taps[i] = '0;
      tap_count = TAP_COUNT_RESET;
      errors = 0;
    endfunction

    // zero counts as one tap, oversize counts saturate
    function int active_taps();
      int n;
      n = tap_count;
      if (n == 0) n = 1;
      if (n > TB_TAPS) n = TB_TAPS;
      return n;
    endfunction

    function void shift_in(logic signed [DATA_W-1:0] s);
      for (int i = TB_TAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
      delay_line[0] = s;
    endfunction

    // exact sum of products, wrapped to the output width
    function logic signed [SUM_W-1:0] tap_sum(int n);
      longint acc;
      acc = 0;
      for (int j = 0; j < n; j++) acc += longint'(taps[j]) * longint'(delay_line[j]);
      return acc[SUM_W-1:0];
    endfunction

    function void accept_input(in_t item);
      int   n;
      out_t res;
      if (item.mode == MODE_LOAD) begin
        if (item.tap_index < TB_TAPS) taps[item.tap_index] = item.coefficient;
        return;
      end
      n = active_taps();
      shift_in(item.sample);
      res.filtered_out = tap_sum(n);
      res.last_out = item.last_sample && (n == 1);
      expected_outputs.push_back(res);
      // tail flush with zeros, then the delay line clears
      if (item.last_sample) begin
        for (int k = 1; k < n; k++) begin
          shift_in('0);
          res.filtered_out = tap_sum(n);
          res.last_out = (k == n - 1);
          expected_outputs.push_back(res);
        end
        foreach (delay_line[i]) delay_line[i] = '0;
      end
    endfunction

    function void check_output(out_t got);
      out_t want;
      if (expected_outputs.size() == 0) begin
        $error("unexpected output transaction: filtered_out %0d last_out %0d",
               got.filtered_out, got.last_out);
        errors++;
        return;
      end
      want = expected_outputs.pop_front();
      if (got.filtered_out !== want.filtered_out) begin
        $error("filtered_out mismatch: expected %0d, actual %0d",
               want.filtered_out, got.filtered_out);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out mismatch: expected %0d, actual %0d", want.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;

  fir_conv_tracker tracker = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;

  fir_convolution_stream_top #(
    .TAPS(TB_TAPS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // check each accepted output transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_output(out_data);
  end

  function automatic logic signed [DATA_W-1:0] rand_s16();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic in_t make_load(logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] coef);
    in_t item;
    item.mode        = MODE_LOAD;
    item.tap_index   = idx;
    item.coefficient = coef;
    item.sample      = DATA_W'($urandom);
    item.last_sample = $urandom_range(1);
    return item;
  endfunction

  function automatic in_t make_push(logic signed [DATA_W-1:0] smp, logic last);
    in_t item;
    item.mode        = MODE_PUSH;
    item.tap_index   = IDX_W'($urandom);
    item.coefficient = DATA_W'($urandom);
    item.sample      = smp;
    item.last_sample = last;
    return item;
  endfunction

  // hold one transaction on the input channel until it is taken
  task automatic send_item(input in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.accept_input(item);
    items_sent++;
  endtask

  // all predicted outputs seen, plus room for an in-flight load
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tap_count(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.tap_count = value;
  endtask

  task automatic set_idling(input int profile);
    case (profile)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // one random group: coefficient updates or a sample stream
  task automatic run_burst();
    int               kind;
    int               len;
    logic signed [DATA_W-1:0] full_scale;
    kind = $urandom_range(19);
    if (kind == 0) begin
      // whole store at one full-scale polarity
      full_scale = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      for (int i = 0; i < TB_TAPS; i++) send_item(make_load(IDX_W'(i), full_scale));
    end else if (kind < 6) begin
      len = $urandom_range(1, 4);
      repeat (len) send_item(make_load(IDX_W'($urandom_range(TB_TAPS - 1)), rand_s16()));
    end else begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0)
          send_item(make_load(IDX_W'($urandom_range(TB_TAPS - 1)), rand_s16()));
        send_item(make_push(rand_s16(), (i == len - 1) && ($urandom_range(99) < 85)));
      end
    end
  endtask

  function automatic logic [CNT_W-1:0] pick_tap_count();
    case ($urandom_range(9))
      0:       return CNT_W'(1);
      1:       return CNT_W'(32);
      2:       return CNT_W'(0);
      3:       return CNT_W'(63);
      4:       return CNT_W'(33);
      5:       return CNT_W'($urandom_range(2, 4));
      default: return CNT_W'($urandom_range(1, 32));
    endcase
  endfunction

  initial begin
    int blk;
    int start;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full-scale and small taps and samples over all 32 taps
    write_tap_count(CNT_W'(32));
    send_item('{mode: MODE_LOAD, tap_index: 5'd0, coefficient: 16'sh7fff,
                sample: 16'sh0000, last_sample: 1'b1});
    send_item(make_load(IDX_W'(31), 16'sh8000));
    send_item(make_load(IDX_W'(1), 16'sh8000));
    send_item(make_load(IDX_W'(2), -16'sd1));
    send_item(make_push(16'sh7fff, 1'b0));
    send_item(make_push(16'sh8000, 1'b0));
    send_item(make_push(16'sh0000, 1'b0));
    send_item(make_push(16'sd1, 1'b0));
    send_item(make_push(-16'sd1, 1'b1));

    // single tap: the one output carries last_out
    write_tap_count(CNT_W'(1));
    send_item(make_push(16'sd12345, 1'b1));
    send_item(make_push(16'sh8000, 1'b0));
    send_item(make_push(16'sh7fff, 1'b1));

    // zero tap count acts as one tap
    write_tap_count(CNT_W'(0));
    send_item(make_push(16'sh8000, 1'b1));

    // oversize tap count saturates
    write_tap_count(CNT_W'(63));
    send_item(make_push(16'sd100, 1'b0));
    send_item(make_push(-16'sd5, 1'b1));

    // two taps then three, history kept across the count change
    write_tap_count(CNT_W'(2));
    send_item(make_push(16'sd7, 1'b0));
    write_tap_count(CNT_W'(3));
    send_item(make_push(16'sh7fff, 1'b1));

    // random phases
    blk = 0;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      set_idling(blk % 4);
      write_tap_count(pick_tap_count());
      repeat ($urandom_range(1, 3)) run_burst();
      blk++;
    end

    wait_idle();
    if (tracker.errors == 0 && tracker.expected_outputs.size() == 0) begin
      $display("[fir_convolution_stream_top] OK");
    end else begin
      $display("[fir_convolution_stream_top] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("[fir_convolution_stream_top] ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/fcs_pkg.sv
hw/rtl/fcs_cell.sv
hw/rtl/fcs_tree.sv
hw/rtl/fir_convolution_stream_top.sv
hw/rtl/fcs_checker.sv
test/tb_top.sv
